>>> rtl/fpts_pkg.sv
// Package: shared types, opcodes and constants for the task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package fpts_pkg;
    localparam int TASK_COUNT_DEF = 8;
    localparam logic [31:0] REBASE_STEP = 32'h7fff_ffff;
    localparam logic [31:0] TICK_RESET = 32'd4294957296;
    localparam logic [7:0] LOCK_MAX = 8'd255;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;

    localparam logic [3:0] OP_TICK = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_REMOVE = 4'd2;
    localparam logic [3:0] OP_DELAY = 4'd3;
    localparam logic [3:0] OP_CANCEL = 4'd4;
    localparam logic [3:0] OP_SUSPEND = 4'd5;
    localparam logic [3:0] OP_RESUME = 4'd6;
    localparam logic [3:0] OP_SETPRIO = 4'd7;
    localparam logic [3:0] OP_LOCK = 4'd8;
    localparam logic [3:0] OP_UNLOCK = 4'd9;
    localparam logic [3:0] OP_BLOCK = 4'd10;
    localparam logic [3:0] OP_UNBLOCK = 4'd11;

    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  task_id;
        logic [3:0]  priority_slot;
        logic [31:0] delay_ticks;
    } t_cmd;

    typedef struct packed {
        logic       status;
        logic [2:0] assigned_task;
        logic [2:0] current_task;
        logic [3:0] task_slot;
    } t_res;

    // Per-task flags and wake time; the controller keeps these in its own arrays instead.
    typedef struct packed {
        logic       running;
        logic       delayed;
        logic       suspended;
        logic       blocked;
        logic [31:0] wake;
    } t_task;
endpackage
`default_nettype wire

>>> rtl/fpts_scan_cell.sv
// One slot cell of the scan chain: tests its slot and passes the token on.
`timescale 1ns / 1ps
`default_nettype none
module fpts_scan_cell #(
    parameter int TASK_COUNT = fpts_pkg::TASK_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic                          i_tok,
    input  wire logic                          i_slot_valid,
    input  wire logic                          i_ready,
    input  wire logic                          i_woken,
    output logic                               o_tok,
    output logic                               o_hit
);
    import fpts_pkg::*;
    logic r_tok;
    logic match;
    assign match = i_slot_valid && (i_ready || i_woken);
    assign o_hit = r_tok && match;
    assign o_tok = r_tok && !match;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end
endmodule
`default_nettype wire

>>> rtl/fixed_priority_task_scheduler_core.sv
// Top level: fixed-priority task scheduler with a chained slot scan.
//  channel | handshake            | payload
//  cmd     | i_start / o_busy     | i_cmd (t_cmd)
//  res     | o_done strobe        | o_res (t_res)
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_data (quantum length)
// An op is taken in S_IDLE, may pass S_REBASE and a scan through the slot cells
// (one cell a cycle), and ends in S_OUT, which strobes the result.
// Reset restores the power-up task table; results need no flow control.
`timescale 1ns / 1ps
`default_nettype none
module fixed_priority_task_scheduler_core #(
    parameter int TASK_COUNT = fpts_pkg::TASK_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire fpts_pkg::t_cmd i_cmd,
    output logic               o_done,
    output fpts_pkg::t_res     o_res,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [15:0]   i_cfg_data
);
    import fpts_pkg::*;
    localparam int TW = $clog2(TASK_COUNT);
    localparam int CW = $clog2(TASK_COUNT + 2);
    localparam logic [3:0] NONE = 4'(TASK_COUNT);

    typedef enum logic [2:0] {S_IDLE, S_REBASE, S_SCAN, S_OUT} t_state;
    t_state r_state;

    logic [TW-1:0] r_owner [TASK_COUNT];
    logic [TASK_COUNT-1:0] r_sv, r_run, r_del, r_sus, r_blk;
    logic [31:0] r_wake [TASK_COUNT];
    logic [31:0] r_tick;
    logic [15:0] r_qc, r_qlen;
    logic [TW-1:0] r_cur;
    logic [7:0] r_lock;
    logic r_status;
    logic [2:0] r_assigned;
    logic [3:0] r_id;
    logic r_done;
    logic [CW-1:0] r_cnt;
    logic r_seed;

    assign o_busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done = r_done;

    // scan chain
    logic [TASK_COUNT:0] tok;
    logic [TASK_COUNT-1:0] hit;
    assign tok[0] = r_seed;
    for (genvar s = 0; s < TASK_COUNT; s++) begin : g_cell
        logic [TW-1:0] t;
        assign t = r_owner[s];
        fpts_scan_cell #(.TASK_COUNT(TASK_COUNT)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(r_state != S_SCAN),
            .i_tok(tok[s]), .i_slot_valid(r_sv[s]),
            .i_ready(r_run[t] && !r_del[t] && !r_sus[t] && !r_blk[t]),
            .i_woken(r_del[t] && (r_tick >= r_wake[t])),
            .o_tok(tok[s+1]), .o_hit(hit[s]));
    end

    // slot lookup for an id
    function automatic logic [3:0] slot_of(input logic [3:0] id,
        input logic [TASK_COUNT-1:0] sv, input logic [TW-1:0] own [TASK_COUNT]);
        logic [3:0] r;
        r = NONE;
        for (int s = TASK_COUNT - 1; s >= 0; s--)
            if (sv[s] && {1'b0, own[s]} == {1'b0, id[TW-1:0]} && id < 4'(TASK_COUNT))
                r = 4'(s);
        return r;
    endfunction

    logic [TW-1:0] free_t;
    logic free_ok;
    always_comb begin
        free_t = '0;
        free_ok = 1'b0;
        for (int t = TASK_COUNT - 1; t >= 0; t--)
            if (!r_run[t]) begin
                free_t = TW'(t);
                free_ok = 1'b1;
            end
    end

    logic [3:0] old_slot;
    assign old_slot = slot_of(i_cmd.task_id, r_sv, r_owner);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sv <= '0;
            r_sv[TASK_COUNT-2] <= 1'b1;
            r_sv[TASK_COUNT-1] <= 1'b1;
            r_run <= '0;
            r_run[0] <= 1'b1;
            r_run[1] <= 1'b1;
            r_del <= '0;
            r_sus <= '0;
            r_blk <= '0;
            for (int s = 0; s < TASK_COUNT; s++) r_owner[s] <= '0;
            r_owner[TASK_COUNT-1] <= TW'(1);
            r_tick <= TICK_RESET;
            r_qc <= '0;
            r_qlen <= QUANTUM_RESET;
            r_cur <= '0;
            r_lock <= '0;
            r_done <= 1'b0;
            r_seed <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            r_seed <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) r_qlen <= i_cfg_data;
                    if (i_start) begin
                        logic id_ok, sl_ok, pass;
                        logic [TW-1:0] id;
                        logic [TW-1:0] sl;
                        id_ok = i_cmd.task_id < 4'(TASK_COUNT);
                        sl_ok = i_cmd.priority_slot < 4'(TASK_COUNT);
                        id = i_cmd.task_id[TW-1:0];
                        sl = i_cmd.priority_slot[TW-1:0];
                        pass = 1'b0;
                        r_status <= 1'b0;
                        r_assigned <= '0;
                        r_id <= i_cmd.task_id;
                        r_state <= S_OUT;
                        case (i_cmd.op)
                            OP_TICK: begin
                                r_tick <= r_tick + 32'd1;
                                if (r_qc + 16'd1 >= r_qlen) begin
                                    r_qc <= '0;
                                    if (r_tick + 32'd1 > REBASE_STEP) r_state <= S_REBASE;
                                    else pass = 1'b1;
                                end else begin
                                    r_qc <= r_qc + 16'd1;
                                end
                            end
                            OP_ADD: begin
                                if (!sl_ok || !free_ok || r_sv[sl]) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_run[free_t] <= 1'b1;
                                    r_owner[sl] <= free_t;
                                    r_sv[sl] <= 1'b1;
                                    r_assigned <= 3'(free_t);
                                end
                            end
                            OP_REMOVE: begin
                                if (!id_ok) r_status <= 1'b1;
                                else begin
                                    r_run[id] <= 1'b0;
                                    for (int s = 0; s < TASK_COUNT; s++)
                                        if (r_owner[s] == id) r_sv[s] <= 1'b0;
                                    pass = 1'b1;
                                end
                            end
                            OP_DELAY: begin
                                if (!id_ok) r_status <= 1'b1;
                                else begin
                                    r_wake[id] <= r_tick + i_cmd.delay_ticks;
                                    r_del[id] <= 1'b1;
                                    pass = 1'b1;
                                end
                            end
                            OP_CANCEL: begin
                                if (!id_ok) r_status <= 1'b1;
                                else begin
                                    r_del[id] <= 1'b0;
                                    pass = 1'b1;
                                end
                            end
                            OP_SUSPEND: begin
                                if (!id_ok) r_status <= 1'b1;
                                else begin
                                    r_sus[id] <= 1'b1;
                                    pass = 1'b1;
                                end
                            end
                            OP_RESUME: begin
                                if (!id_ok) r_status <= 1'b1;
                                else r_sus[id] <= 1'b0;
                            end
                            OP_SETPRIO: begin
                                if (!id_ok || !sl_ok) r_status <= 1'b1;
                                else begin
                                    if (!r_sv[sl]) begin
                                        if (old_slot != NONE) r_sv[old_slot[TW-1:0]] <= 1'b0;
                                        r_owner[sl] <= id;
                                        r_sv[sl] <= 1'b1;
                                    end
                                    pass = 1'b1;
                                end
                            end
                            OP_LOCK: if (r_lock < LOCK_MAX) r_lock <= r_lock + 8'd1;
                            OP_UNLOCK: begin
                                if (r_lock != '0) begin
                                    r_lock <= r_lock - 8'd1;
                                    if (r_lock == 8'd1) pass = 1'b1;
                                end
                            end
                            OP_BLOCK: begin
                                r_blk[r_cur] <= 1'b1;
                                pass = 1'b1;
                            end
                            OP_UNBLOCK: begin
                                r_blk <= '0;
                                pass = 1'b1;
                            end
                            default: r_status <= 1'b1;
                        endcase
                        // unlock to zero still scans; otherwise hold while locked
                        if (pass && (r_lock == '0 || i_cmd.op == OP_UNLOCK)) begin
                            r_state <= S_SCAN;
                            r_seed <= 1'b1;
                            r_cnt <= '0;
                        end
                    end
                end
                S_REBASE: begin
                    r_tick <= r_tick - REBASE_STEP;
                    for (int t = 0; t < TASK_COUNT; t++)
                        if (r_del[t]) r_wake[t] <= r_wake[t] - REBASE_STEP;
                    if (r_lock == '0) begin
                        r_state <= S_SCAN;
                        r_seed <= 1'b1;
                        r_cnt <= '0;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    for (int s = 0; s < TASK_COUNT; s++)
                        if (hit[s]) begin
                            r_cur <= r_owner[s];
                            r_del[r_owner[s]] <= 1'b0;
                        end
                    if (hit != '0 || r_cnt == CW'(TASK_COUNT)) r_state <= S_OUT;
                end
                S_OUT: begin
                    o_res.status <= r_status;
                    o_res.assigned_task <= r_assigned;
                    o_res.current_task <= 3'(r_cur);
                    o_res.task_slot <= slot_of(r_id, r_sv, r_owner);
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(hit))
        else $error("more than one cell claimed the scan");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done)
        else $error("result strobe held");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CW'(TASK_COUNT)))
        else $error("scan overran the chain");
    a_tok_one: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(tok))
        else $error("scan token duplicated");
endmodule
`default_nettype wire

>>> tb/tb_fixed_priority_task_scheduler_core.sv
// Testbench: scheduler ops checked against a cycle-free predictor of the task table.
`timescale 1ns / 1ps
`default_nettype none
module tb_fixed_priority_task_scheduler_core;
    import fpts_pkg::*;

    localparam int NT = TASK_COUNT_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_cmd        i_cmd;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    fixed_priority_task_scheduler_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cmd(i_cmd), .o_done(o_done), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [2:0]  sch_owner [NT];
    logic        sch_valid [NT];
    logic        tsk_run [NT];
    logic        tsk_dly [NT];
    logic        tsk_susp [NT];
    logic        tsk_blk [NT];
    logic [31:0] tsk_wake [NT];
    logic [31:0] sch_ticks;
    logic [15:0] sch_qcount;
    logic [15:0] sch_qlen;
    logic [2:0]  sch_cur;
    logic [7:0]  sch_lock;

    t_cmd cmd_queue [$];
    t_res expected_res [$];
    int   error_count = 0;
    bit   stim_done = 0;

    function automatic void scheduler_reset();
        for (int i = 0; i < NT; i++) begin
            sch_owner[i] = '0; sch_valid[i] = 0; tsk_run[i] = 0;
            tsk_dly[i] = 0; tsk_susp[i] = 0; tsk_blk[i] = 0; tsk_wake[i] = '0;
        end
        sch_owner[NT-2] = 3'd0; sch_valid[NT-2] = 1;
        sch_owner[NT-1] = 3'd1; sch_valid[NT-1] = 1;
        tsk_run[0] = 1; tsk_run[1] = 1;
        sch_ticks = TICK_RESET; sch_qcount = '0; sch_cur = '0; sch_lock = '0;
        sch_qlen = QUANTUM_RESET;
    endfunction

    function automatic void reschedule();
        int t;
        if (sch_lock != 0) return;
        for (int s = 0; s < NT; s++) begin
            if (!sch_valid[s]) continue;
            t = sch_owner[s];
            if (tsk_run[t] && !tsk_dly[t] && !tsk_susp[t] && !tsk_blk[t]) begin
                sch_cur = 3'(t); return;
            end
            if (tsk_dly[t] && sch_ticks >= tsk_wake[t]) begin
                tsk_dly[t] = 0; sch_cur = 3'(t); return;
            end
        end
    endfunction

    function automatic int slot_held(int t);
        for (int s = 0; s < NT; s++)
            if (sch_valid[s] && sch_owner[s] == t) return s;
        return NT;
    endfunction

    function automatic t_res schedule_op(t_cmd c);
        t_res r;
        int   id, sl, t, old;
        bit   id_ok, sl_ok;
        id = c.task_id; sl = c.priority_slot;
        id_ok = id < NT; sl_ok = sl < NT;
        r = '0;
        case (c.op)
            OP_TICK: begin
                sch_qcount++; sch_ticks++;
                if (sch_qcount >= sch_qlen) begin
                    if (sch_ticks > REBASE_STEP) begin
                        sch_ticks -= REBASE_STEP;
                        for (int i = 0; i < NT; i++)
                            if (tsk_dly[i]) tsk_wake[i] -= REBASE_STEP;
                    end
                    sch_qcount = '0;
                    reschedule();
                end
            end
            OP_ADD: begin
                t = 0;
                if (!sl_ok) r.status = 1;
                else begin
                    while (t < NT && tsk_run[t]) t++;
                    if (t >= NT || sch_valid[sl]) r.status = 1;
                    else begin
                        tsk_run[t] = 1; sch_owner[sl] = 3'(t); sch_valid[sl] = 1;
                        r.assigned_task = 3'(t);
                    end
                end
            end
            OP_REMOVE: if (!id_ok) r.status = 1; else begin
                tsk_run[id] = 0;
                for (int i = 0; i < NT; i++)
                    if (sch_valid[i] && sch_owner[i] == id) sch_valid[i] = 0;
                reschedule();
            end
            OP_DELAY: if (!id_ok) r.status = 1; else begin
                tsk_wake[id] = sch_ticks + c.delay_ticks; tsk_dly[id] = 1;
                reschedule();
            end
            OP_CANCEL: if (!id_ok) r.status = 1; else begin
                tsk_dly[id] = 0; reschedule();
            end
            OP_SUSPEND: if (!id_ok) r.status = 1; else begin
                tsk_susp[id] = 1; reschedule();
            end
            OP_RESUME: if (!id_ok) r.status = 1; else tsk_susp[id] = 0;
            OP_SETPRIO: if (!id_ok || !sl_ok) r.status = 1; else begin
                old = slot_held(id);
                if (!sch_valid[sl]) begin
                    sch_owner[sl] = 3'(id); sch_valid[sl] = 1;
                    if (old < NT) sch_valid[old] = 0;
                end
                reschedule();
            end
            OP_LOCK: if (sch_lock < LOCK_MAX) sch_lock++;
            OP_UNLOCK: if (sch_lock > 0) begin
                sch_lock--;
                if (sch_lock == 0) reschedule();
            end
            OP_BLOCK: begin
                tsk_blk[sch_cur] = 1; reschedule();
            end
            OP_UNBLOCK: begin
                for (int i = 0; i < NT; i++) tsk_blk[i] = 0;
                reschedule();
            end
            default: r.status = 1;
        endcase
        r.current_task = sch_cur;
        r.task_slot = id_ok ? 4'(slot_held(id)) : 4'(NT);
        return r;
    endfunction

    function automatic t_cmd make_cmd(int op, int id, int sl, logic [31:0] d);
        t_cmd c;
        c.op = 4'(op); c.task_id = 4'(id); c.priority_slot = 4'(sl); c.delay_ticks = d;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        int op, r;
        logic [31:0] d;
        r = $urandom_range(0, 99);
        // mostly tick and well-formed task ops; a few bad ids, slots and opcodes
        if (r < 30) op = OP_TICK;
        else if (r < 97) op = $urandom_range(1, 11);
        else op = $urandom_range(12, 15);
        case ($urandom_range(0, 3))
            0: d = $urandom;
            1: d = 32'hffff_ffff - $urandom_range(0, 3);
            default: d = $urandom_range(0, 40);
        endcase
        return make_cmd(op,
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, NT-1),
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, NT-1),
            d);
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // driver: bursts and gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 0;
        end else if (i_start && !o_busy) begin
            void'(cmd_queue.pop_front());
            expected_res.push_back(schedule_op(i_cmd));
            if (burst_left > 0) burst_left--;
            if (cmd_queue.size() > 0 && burst_left > 0) begin
                i_cmd <= cmd_queue[0];
            end else begin
                i_start <= 0;
                gap_left <= (burst_left == 0) ? $urandom_range(0, 30) : 0;
            end
        end else if (!i_start) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            else if (cmd_queue.size() > 0) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 20);
                i_cmd <= cmd_queue[0];
                i_start <= 1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done) begin
            if (expected_res.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $realtime, o_res);
                error_count++;
            end else begin
                e = expected_res.pop_front();
                if (o_res.status !== e.status)
                    $display("%0t: status exp %0d act %0d", $realtime, e.status, o_res.status);
                if (o_res.assigned_task !== e.assigned_task)
                    $display("%0t: assigned_task exp %0d act %0d", $realtime,
                             e.assigned_task, o_res.assigned_task);
                if (o_res.current_task !== e.current_task)
                    $display("%0t: current_task exp %0d act %0d", $realtime,
                             e.current_task, o_res.current_task);
                if (o_res.task_slot !== e.task_slot)
                    $display("%0t: task_slot exp %0d act %0d", $realtime,
                             e.task_slot, o_res.task_slot);
                if (o_res !== e) error_count++;
            end
        end
    end

    task automatic write_quantum(logic [15:0] q);
        @(posedge i_clk);
        i_cfg_data <= q;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sch_qlen = q;
        i_cfg_valid <= 0;
    endtask

    // wait until every queued transfer has been sent and answered
    task automatic drain();
        while (!(cmd_queue.size() == 0 && !i_start && expected_res.size() == 0))
            @(posedge i_clk);
        repeat (NT + 8) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] qset [5];
        i_rst_n = 0; i_start = 0; i_cmd = '0; i_cfg_valid = 0; i_cfg_data = '0;
        scheduler_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: errors, extremes, delay wrap, lock, block
        cmd_queue.push_back(make_cmd(OP_ADD, 0, 15, 0));
        cmd_queue.push_back(make_cmd(OP_ADD, 0, NT-2, 0));
        cmd_queue.push_back(make_cmd(OP_ADD, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_REMOVE, 15, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SETPRIO, 2, 15, 0));
        cmd_queue.push_back(make_cmd(OP_SETPRIO, 2, NT-1, 0));
        cmd_queue.push_back(make_cmd(OP_DELAY, 2, 0, 32'hffff_ffff));
        cmd_queue.push_back(make_cmd(OP_DELAY, 0, 0, 32'd5));
        cmd_queue.push_back(make_cmd(OP_CANCEL, 2, 0, 0));
        cmd_queue.push_back(make_cmd(OP_SUSPEND, 2, 0, 0));
        cmd_queue.push_back(make_cmd(OP_RESUME, 2, 0, 0));
        cmd_queue.push_back(make_cmd(OP_LOCK, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_BLOCK, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_UNLOCK, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_UNLOCK, 0, 0, 0));
        cmd_queue.push_back(make_cmd(OP_UNBLOCK, 0, 0, 0));
        cmd_queue.push_back(make_cmd(4'd12, 15, 15, 0));
        cmd_queue.push_back(make_cmd(4'd15, 8, 8, 32'haaaa_5555));
        for (int i = 0; i < 7; i++) cmd_queue.push_back(make_cmd(OP_TICK, 0, 0, 0));
        drain();
        // lock saturation
        for (int i = 0; i < 260; i++) cmd_queue.push_back(make_cmd(OP_LOCK, 0, 0, 0));
        for (int i = 0; i < 256; i++) cmd_queue.push_back(make_cmd(OP_UNLOCK, 0, 0, 0));
        drain();
        qset = '{16'd0, 16'd1, 16'd65535, 16'd3, 16'd10};
        for (int p = 0; p < 5; p++) begin
            write_quantum(qset[p]);
            for (int i = 0; i < 180; i++) cmd_queue.push_back(random_cmd());
            drain();
        end
        stim_done = 1;
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
